FILE: rtl/assert_macros.svh
// Assertion macros used by triangle_unit_normal
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

FILE: rtl/tun_pkg.sv
// Widths and types for the triangle unit normal pipeline
`timescale 1ns / 1ps
`default_nettype none
package tun_pkg;
  localparam int COORD_WIDTH  = 16;
  localparam int NORMAL_WIDTH = 16;
  localparam int EDGE_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int HALF_W  = (MAG_W + 1) / 2;
  localparam int HI_W    = MAG_W - HALF_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int Q_W     = NORMAL_WIDTH - 1;
  localparam int ACC_W   = SUM_W + 2 * Q_W + 1;

  typedef logic signed [COORD_WIDTH-1:0]  coord_t;
  typedef logic signed [NORMAL_WIDTH-1:0] norm_t;
  typedef logic signed [EDGE_W-1:0]       edge_t;
  typedef logic signed [PROD_W-1:0]       prod_t;
  typedef logic [MAG_W-1:0]               mag_t;
  typedef logic [SQ_W-1:0]                sq_t;
  typedef logic [SUM_W-1:0]               sum_t;
  typedef logic [ACC_W-1:0]               acc_t;
  typedef logic [Q_W-1:0]                 quot_t;
endpackage
`default_nettype wire

FILE: rtl/tun_if.sv
// Handshake channels for corner words and normal words
`timescale 1ns / 1ps
`default_nettype none
interface tun_in_if import tun_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
  modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
  modport sink (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface tun_out_if import tun_pkg::*; ();
  logic  valid;
  logic  ready;
  norm_t nx, ny, nz;
  logic  degenerate;
  modport source (output valid, nx, ny, nz, degenerate, input ready);
  modport sink (input valid, nx, ny, nz, degenerate, output ready);
endinterface
`default_nettype wire

FILE: rtl/triangle_unit_normal.sv
// Triangle unit normal: edge vectors, cross product, exact normalisation to Q1.15
//
// Takes one triangle word per clock and returns one normal word per triangle
// through the output register. Six front stages form edges, the cross product
// and its squared length S; fifteen back stages each settle one bit of all
// three components with a restoring search (one wide add and compare per
// component per stage), so the result is exact truncation of P/|P|, saturated
// to 32767. When the output word is not taken the whole pipe holds; ready
// is high whenever the output register is empty or being taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module triangle_unit_normal import tun_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  tun_in_if.sink     corners,
  tun_out_if.source  normal
);
  logic en;
  assign en = !normal.valid || normal.ready;
  assign corners.ready = en;

  coord_t a [3];
  coord_t b [3];
  coord_t c [3];
  assign a[0] = corners.ax; assign a[1] = corners.ay; assign a[2] = corners.az;
  assign b[0] = corners.bx; assign b[1] = corners.by; assign b[2] = corners.bz;
  assign c[0] = corners.cx; assign c[1] = corners.cy; assign c[2] = corners.cz;

  // stage 1: edges
  logic  vld1;
  edge_t e1 [3];
  edge_t e2 [3];
  always_ff @(posedge clk) begin
    if (rst) vld1 <= 1'b0;
    else if (en) vld1 <= corners.valid;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= edge_t'(b[i]) - edge_t'(a[i]);
        e2[i] <= edge_t'(c[i]) - edge_t'(a[i]);
      end
    end
  end

  // stage 2: six partial products
  logic  vld2;
  prod_t pr [6];
  always_ff @(posedge clk) begin
    if (rst) vld2 <= 1'b0;
    else if (en) vld2 <= vld1;
    if (en) begin
      pr[0] <= e1[1] * e2[2];
      pr[1] <= e1[2] * e2[1];
      pr[2] <= e1[2] * e2[0];
      pr[3] <= e1[0] * e2[2];
      pr[4] <= e1[0] * e2[1];
      pr[5] <= e1[1] * e2[0];
    end
  end

  // stage 3: cross product as sign and magnitude
  logic vld3;
  logic sgn3 [3];
  mag_t mag3 [3];
  logic signed [CROSS_W-1:0] cross_p [3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      cross_p[i] = CROSS_W'(pr[2*i]) - CROSS_W'(pr[2*i+1]);
  end
  always_ff @(posedge clk) begin
    if (rst) vld3 <= 1'b0;
    else if (en) vld3 <= vld2;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sgn3[i] <= cross_p[i][CROSS_W-1];
        mag3[i] <= cross_p[i][CROSS_W-1] ? MAG_W'(-cross_p[i]) : MAG_W'(cross_p[i]);
      end
    end
  end

  // stage 4: squares split into half-width partial products
  logic vld4;
  logic sgn4 [3];
  logic [2*HI_W-1:0]     hh [3];
  logic [MAG_W-1:0]      hl [3];
  logic [2*HALF_W-1:0]   ll [3];
  always_ff @(posedge clk) begin
    if (rst) vld4 <= 1'b0;
    else if (en) vld4 <= vld3;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sgn4[i] <= sgn3[i];
        hh[i] <= mag3[i][MAG_W-1:HALF_W] * mag3[i][MAG_W-1:HALF_W];
        hl[i] <= mag3[i][MAG_W-1:HALF_W] * mag3[i][HALF_W-1:0];
        ll[i] <= mag3[i][HALF_W-1:0] * mag3[i][HALF_W-1:0];
      end
    end
  end

  // stage 5: assemble squares
  logic vld5;
  logic sgn5 [3];
  sq_t  sq5 [3];
  always_ff @(posedge clk) begin
    if (rst) vld5 <= 1'b0;
    else if (en) vld5 <= vld4;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sgn5[i] <= sgn4[i];
        sq5[i]  <= (SQ_W'(hh[i]) << (2 * HALF_W)) + (SQ_W'(hl[i]) << (HALF_W + 1))
                 + SQ_W'(ll[i]);
      end
    end
  end

  // stage 6 feeds the bit stages: index 0 holds the start of the search
  logic  it_vld [Q_W+1];
  logic  it_dg  [Q_W+1];
  sum_t  it_s   [Q_W+1];
  logic  it_sgn [Q_W+1][3];
  acc_t  it_r   [Q_W+1][3];
  acc_t  it_t   [Q_W+1][3];
  quot_t it_q   [Q_W+1][3];

  sum_t s_sum;
  assign s_sum = SUM_W'(sq5[0]) + SUM_W'(sq5[1]) + SUM_W'(sq5[2]);

  always_ff @(posedge clk) begin
    if (rst) it_vld[0] <= 1'b0;
    else if (en) it_vld[0] <= vld5;
    if (en) begin
      it_s[0]  <= s_sum;
      it_dg[0] <= (s_sum == '0);
      for (int i = 0; i < 3; i++) begin
        it_sgn[0][i] <= sgn5[i];
        it_r[0][i]   <= ACC_W'(sq5[i]) << (2 * Q_W);
        it_t[0][i]   <= '0;
        it_q[0][i]   <= '0;
      end
    end
  end

  // restoring search: R = m^2*2^2Q - q^2*S, T = q*S
  for (genvar k = 0; k < Q_W; k++) begin : g_bit
    localparam int B = Q_W - 1 - k;
    acc_t cand [3];
    logic take [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        cand[i] = (it_t[k][i] << (B + 1)) + (ACC_W'(it_s[k]) << (2 * B));
        take[i] = (cand[i] <= it_r[k][i]);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) it_vld[k+1] <= 1'b0;
      else if (en) it_vld[k+1] <= it_vld[k];
      if (en) begin
        it_s[k+1]  <= it_s[k];
        it_dg[k+1] <= it_dg[k];
        for (int i = 0; i < 3; i++) begin
          it_sgn[k+1][i] <= it_sgn[k][i];
          if (take[i]) begin
            it_r[k+1][i] <= it_r[k][i] - cand[i];
            it_t[k+1][i] <= it_t[k][i] + (ACC_W'(it_s[k]) << B);
            it_q[k+1][i] <= it_q[k][i] | (quot_t'(1) << B);
          end else begin
            it_r[k+1][i] <= it_r[k][i];
            it_t[k+1][i] <= it_t[k][i];
            it_q[k+1][i] <= it_q[k][i];
          end
        end
      end
    end
  end

  // output register
  norm_t res [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (it_dg[Q_W]) res[i] = '0;
      else if (it_sgn[Q_W][i]) res[i] = -norm_t'({1'b0, it_q[Q_W][i]});
      else res[i] = norm_t'({1'b0, it_q[Q_W][i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) normal.valid <= 1'b0;
    else if (en) normal.valid <= it_vld[Q_W];
    if (en) begin
      normal.nx         <= res[0];
      normal.ny         <= res[1];
      normal.nz         <= res[2];
      normal.degenerate <= it_dg[Q_W];
    end
  end

  `ASSERT_CLK(a_degen_zero, normal.valid && normal.degenerate |->
    normal.nx == '0 && normal.ny == '0 && normal.nz == '0)
  `ASSERT_CLK(a_live_nonzero, normal.valid && !normal.degenerate |->
    normal.nx != '0 || normal.ny != '0 || normal.nz != '0)
  `ASSERT_NEVER(a_no_minus_one, normal.valid && (normal.nx == norm_t'(1 << Q_W) ||
    normal.ny == norm_t'(1 << Q_W) || normal.nz == norm_t'(1 << Q_W)))
  `ASSERT_CLK(a_ready_tracks_out, corners.ready == (!normal.valid || normal.ready))
endmodule
`default_nettype wire
